>>> rtl/core/rss_pkg.sv
// Package for the reservation station scheduler: payload structs, op codes,
// controller/datapath command and status structs. No dependencies.
package rss_pkg;

	localparam int XLEN = 32;

	// operation codes
	localparam logic [2:0] OP_ADD  = 3'd0;
	localparam logic [2:0] OP_ADDI = 3'd1;
	localparam logic [2:0] OP_SUB  = 3'd2;
	localparam logic [2:0] OP_MUL  = 3'd3;
	localparam logic [2:0] OP_DIV  = 3'd4;

	// configuration register indexes
	localparam logic [1:0] CFG_ADD_LAT = 2'd0;
	localparam logic [1:0] CFG_MUL_LAT = 2'd1;
	localparam logic [1:0] CFG_DIV_LAT = 2'd2;

	typedef struct packed {
		logic        has_instruction;
		logic [2:0]  operation;
		logic [2:0]  dest_reg;
		logic [2:0]  src1_reg;
		logic [2:0]  src2_reg;
		logic signed [31:0] immediate;
	} rss_in_t;

	typedef struct packed {
		logic        issue_accepted;
		logic        add_done;
		logic [1:0]  add_station;
		logic signed [31:0] add_value;
		logic        mul_done;
		logic [2:0]  mul_station;
		logic signed [31:0] mul_value;
	} rss_out_t;

	// controller -> datapath commands
	typedef struct packed {
		logic load;       // capture the input item, start unit phase
		logic run_units;  // evaluate unit completion / countdown
		logic start_div;  // launch the divider
		logic finish;     // broadcast, dispatch, issue, latch result
	} rss_cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic need_div;   // multiply unit finishes with a divide
		logic div_done;
	} rss_sts_t;

endpackage

>>> rtl/core/rss_div.sv
// Radix-2 signed divider (truncating, divide by zero gives 0).
// Depends on rss_pkg.
module rss_div
	import rss_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic        done,
	output logic [31:0] quot
);
	logic [31:0] rem_q, quo_q, div_q;
	logic [5:0]  cnt_q;
	logic        busy_q, neg_q, zero_q;
	logic [32:0] trial;

	assign trial = {rem_q, quo_q[31]} - {1'b0, div_q};

	// one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quo_q  <= a[31] ? -a : a;
			div_q  <= b[31] ? -b : b;
			neg_q  <= a[31] ^ b[31];
			zero_q <= (b == 32'd0);
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign quot = zero_q ? 32'd0 : (neg_q ? -quo_q : quo_q);
endmodule

>>> rtl/core/rss_ctrl.sv
// Controller state machine for one tick of the scheduler.
// Depends on rss_pkg.
module rss_ctrl
	import rss_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  rss_sts_t sts,
	output rss_cmd_t cmd
);
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_UNIT = 5'b00010,
		ST_DIV  = 5'b00100,
		ST_WAIT = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   ovalid_q;

	// a new tick may start once the output register is free or draining
	assign in_ready  = (state_q == ST_IDLE) && (!ovalid_q || out_ready);
	assign out_valid = ovalid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && in_ready) begin
					cmd.load = 1'b1;
					state_d  = ST_UNIT;
				end
			end
			ST_UNIT: begin
				cmd.run_units = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (sts.need_div) begin
					cmd.start_div = 1'b1;
					state_d = ST_WAIT;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_WAIT: begin
				if (sts.div_done) state_d = ST_FIN;
			end
			ST_FIN: begin
				cmd.finish = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) ovalid_q <= 1'b1;
			else if (out_ready) ovalid_q <= 1'b0;
		end
	end
endmodule

>>> rtl/core/rss_dp.sv
// Datapath: registers, rename table, stations, units, output register.
// Depends on rss_pkg and rss_div.
module rss_dp
	import rss_pkg::*;
#(
	parameter int NUM_REGS     = 5,
	parameter int ADD_STATIONS = 3,
	parameter int MUL_STATIONS = 2
) (
	input  logic     clk,
	input  logic     arst_n,
	input  rss_cmd_t cmd,
	output rss_sts_t sts,
	input  rss_in_t  in_data,
	input  logic [5:0] add_lat,
	input  logic [5:0] mul_lat,
	input  logic [5:0] div_lat,
	output rss_out_t out_data
);
	localparam int NST = ADD_STATIONS + MUL_STATIONS;
	localparam int TW  = $clog2(NST + 1);
	localparam int SW  = (NST > 1) ? $clog2(NST) : 1;
	localparam int RW  = $clog2(NUM_REGS + 1);

	typedef struct packed {
		logic          busy;
		logic          alt;
		logic [SW-1:0] st;
		logic [5:0]    cnt;
	} unit_t;

	logic [31:0]   regv_q [NUM_REGS];
	logic [TW-1:0] tag_q  [NUM_REGS];
	logic          sbusy_q [NST];
	logic          sra_q   [NST];
	logic          srb_q   [NST];
	logic          salt_q  [NST];
	logic [31:0]   sa_q    [NST];
	logic [31:0]   sb_q    [NST];
	unit_t         au_q, mu_q;
	logic [31:0]   aop0_q, aop1_q, mop0_q, mop1_q;
	logic          first_q;
	rss_in_t       item_q;

	// unit phase results, registered between cycles
	logic          adone_s1, mdone_s1;
	logic [31:0]   aval_s1, prod_s1;
	logic [NST-1:0] ready_s1;
	logic          div_done;
	logic [31:0]   quot;

	rss_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.start_div),
		.a     (mop0_q),
		.b     (mop1_q),
		.done  (div_done),
		.quot  (quot)
	);

	logic a_fire, m_fire;
	assign a_fire = !first_q && au_q.busy && (au_q.cnt == 6'd0);
	assign m_fire = !first_q && mu_q.busy && (mu_q.cnt == 6'd0);
	assign sts.need_div = mdone_s1 && mu_q.alt;
	assign sts.div_done = div_done;

	// final tick combinational view
	logic [31:0] mres;
	logic [TW-1:0] atag, mtag;
	assign mres = mu_q.alt ? quot : prod_s1;
	assign atag = TW'(au_q.st) + TW'(1);
	assign mtag = TW'(mu_q.st) + TW'(1);

	logic        op_ok, is_mul, alt_op, found;
	logic [SW-1:0] free_s;
	always_comb begin
		op_ok  = (item_q.operation <= OP_DIV)
			&& item_q.dest_reg != 3'd0 && 32'(item_q.dest_reg) <= NUM_REGS
			&& item_q.src1_reg != 3'd0 && 32'(item_q.src1_reg) <= NUM_REGS
			&& (item_q.operation == OP_ADDI
				|| (item_q.src2_reg != 3'd0 && 32'(item_q.src2_reg) <= NUM_REGS));
		is_mul = (item_q.operation == OP_MUL) || (item_q.operation == OP_DIV);
		alt_op = (item_q.operation == OP_SUB) || (item_q.operation == OP_DIV);
		found  = 1'b0;
		free_s = '0;
		// lowest free station of the class, after the completing ones free
		for (int s = NST - 1; s >= 0; s--) begin
			if ((is_mul ? (s >= ADD_STATIONS) : (s < ADD_STATIONS))
				&& !(sbusy_q[s] && !(adone_s1 && au_q.st == SW'(s))
					&& !(mdone_s1 && mu_q.st == SW'(s)))) begin
				found  = 1'b1;
				free_s = SW'(s);
			end
		end
	end

	// post-broadcast register view for source reads
	function automatic logic [31:0] bval(input logic [TW-1:0] t, input logic [31:0] v,
		input logic ad, input logic md, input logic [TW-1:0] at, input logic [TW-1:0] mt,
		input logic [31:0] av, input logic [31:0] mv, output logic pend);
		logic [31:0] r;
		r = v;
		pend = (t != '0);
		if (pend && ad && t == at) begin r = av; pend = 1'b0; end
		if (pend && md && t == mt) begin r = mv; pend = 1'b0; end
		if (pend) r = 32'(t);
		return r;
	endfunction

	logic [RW-1:0] k1, k2, kd;
	logic [31:0] v1, v2;
	logic        p1, p2, accept;
	always_comb begin
		k1 = RW'(item_q.src1_reg - 3'd1);
		k2 = RW'(item_q.src2_reg - 3'd1);
		kd = RW'(item_q.dest_reg - 3'd1);
		v1 = bval(tag_q[k1], regv_q[k1], adone_s1, mdone_s1, atag, mtag,
			aval_s1, mres, p1);
		v2 = bval(tag_q[k2], regv_q[k2], adone_s1, mdone_s1, atag, mtag,
			aval_s1, mres, p2);
		accept = item_q.has_instruction && op_ok && found;
	end

	// latency selection at dispatch
	function automatic logic [5:0] lat1(input logic [5:0] l);
		return (l == 6'd0) ? 6'd0 : l - 6'd1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < NUM_REGS; r++) tag_q[r] <= '0;
			for (int s = 0; s < NST; s++) sbusy_q[s] <= 1'b0;
			au_q     <= '0;
			mu_q     <= '0;
			first_q  <= 1'b1;
			adone_s1 <= 1'b0;
			mdone_s1 <= 1'b0;
			for (int r = 0; r < NUM_REGS; r++) regv_q[r] <= 32'(2 * r);
		end else begin
			if (cmd.load) adone_s1 <= 1'b0;
			// unit phase: capture readiness, compute, count down
			if (cmd.run_units) begin
				adone_s1 <= a_fire;
				mdone_s1 <= m_fire;
				if (!first_q && au_q.busy && au_q.cnt != 6'd0) au_q.cnt <= au_q.cnt - 6'd1;
				if (!first_q && mu_q.busy && mu_q.cnt != 6'd0) mu_q.cnt <= mu_q.cnt - 6'd1;
			end
			if (cmd.finish) begin
				logic ad_free, md_free, adisp, mdisp;
				ad_free = !au_q.busy || adone_s1;
				md_free = !mu_q.busy || mdone_s1;
				adisp = 1'b0;
				mdisp = 1'b0;
				first_q <= 1'b0;
				// broadcast and free stations
				for (int s = 0; s < NST; s++) begin
					if ((adone_s1 && au_q.st == SW'(s)) || (mdone_s1 && mu_q.st == SW'(s)))
						sbusy_q[s] <= 1'b0;
					else if (sbusy_q[s]) begin
						if (!sra_q[s] && adone_s1 && sa_q[s] == 32'(atag)) begin
							sa_q[s] <= aval_s1; sra_q[s] <= 1'b1;
						end else if (!sra_q[s] && mdone_s1 && sa_q[s] == 32'(mtag)) begin
							sa_q[s] <= mres; sra_q[s] <= 1'b1;
						end
						if (!srb_q[s] && adone_s1 && sb_q[s] == 32'(atag)) begin
							sb_q[s] <= aval_s1; srb_q[s] <= 1'b1;
						end else if (!srb_q[s] && mdone_s1 && sb_q[s] == 32'(mtag)) begin
							sb_q[s] <= mres; srb_q[s] <= 1'b1;
						end
					end
				end
				for (int r = 0; r < NUM_REGS; r++) begin
					if (adone_s1 && tag_q[r] == atag) begin
						tag_q[r] <= '0; regv_q[r] <= aval_s1;
					end else if (mdone_s1 && tag_q[r] == mtag) begin
						tag_q[r] <= '0; regv_q[r] <= mres;
					end
				end
				if (adone_s1) au_q.busy <= 1'b0;
				if (mdone_s1) mu_q.busy <= 1'b0;
				// dispatch lowest ready station (readiness from before broadcast);
				// the station that just completed is free and is skipped
				if (!first_q) begin
					for (int s = 0; s < NST; s++) begin
						if (s < ADD_STATIONS && ad_free && !adisp && ready_s1[s]
							&& !(adone_s1 && au_q.st == SW'(s))) begin
							adisp = 1'b1;
							au_q <= '{busy: 1'b1, alt: salt_q[s], st: SW'(s),
								cnt: lat1(add_lat)};
							aop0_q <= sa_q[s]; aop1_q <= sb_q[s];
						end
						if (s >= ADD_STATIONS && md_free && !mdisp && ready_s1[s]
							&& !(mdone_s1 && mu_q.st == SW'(s))) begin
							mdisp = 1'b1;
							mu_q <= '{busy: 1'b1, alt: salt_q[s], st: SW'(s),
								cnt: lat1(salt_q[s] ? div_lat : mul_lat)};
							mop0_q <= sa_q[s]; mop1_q <= sb_q[s];
						end
					end
				end
				// issue into the lowest free station
				if (accept) begin
					sbusy_q[free_s] <= 1'b1;
					salt_q[free_s]  <= alt_op;
					sa_q[free_s]    <= v1;
					sra_q[free_s]   <= !p1;
					if (item_q.operation == OP_ADDI) begin
						sb_q[free_s]  <= item_q.immediate;
						srb_q[free_s] <= 1'b1;
					end else begin
						sb_q[free_s]  <= v2;
						srb_q[free_s] <= !p2;
					end
					tag_q[kd] <= TW'(free_s) + TW'(1);
				end
			end
		end
	end

	// payload registers of the unit phase and the output
	always_ff @(posedge clk) begin
		if (cmd.load) item_q <= in_data;
		if (cmd.run_units) begin
			aval_s1 <= au_q.alt ? aop0_q - aop1_q : aop0_q + aop1_q;
			prod_s1 <= mop0_q * mop1_q;
			for (int s = 0; s < NST; s++)
				ready_s1[s] <= sbusy_q[s] && sra_q[s] && srb_q[s];
		end
		if (cmd.finish) begin
			out_data.issue_accepted <= accept;
			out_data.add_done    <= adone_s1;
			out_data.add_station <= adone_s1 ? 2'(atag) : 2'd0;
			out_data.add_value   <= adone_s1 ? aval_s1 : 32'd0;
			out_data.mul_done    <= mdone_s1;
			out_data.mul_station <= mdone_s1 ? 3'(mtag) : 3'd0;
			out_data.mul_value   <= mdone_s1 ? mres : 32'd0;
		end
	end
endmodule

>>> rtl/core/reservation_station_scheduler_unit.sv
// Top level of the reservation station scheduler: APB registers, controller,
// datapath. Depends on rss_pkg, rss_ctrl, rss_dp.
//
// channel  | handshake              | payload
// in       | in_valid / in_ready    | in_data  (rss_in_t), one tick
// out      | out_valid / out_ready  | out_data (rss_out_t)
// cfg      | psel penable pwrite    | paddr, pwdata, prdata
//
// A tick steps through load, unit phase, check and finish; a tick whose
// multiply unit completes a divide also waits for the radix-2 divider.
// Reset is asynchronous: registers at 0,2,4..., stations empty, units idle.
// A new tick starts only once the previous result register is free or taken.
module reservation_station_scheduler_unit
	import rss_pkg::*;
#(
	parameter int NUM_REGS     = 5,
	parameter int ADD_STATIONS = 3,
	parameter int MUL_STATIONS = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  rss_in_t     in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output rss_out_t    out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic [5:0] add_lat_q, mul_lat_q, div_lat_q;
	rss_cmd_t   cmd;
	rss_sts_t   sts;

	assign pready = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			add_lat_q <= 6'd2;
			mul_lat_q <= 6'd10;
			div_lat_q <= 6'd40;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				CFG_ADD_LAT: add_lat_q <= pwdata[5:0];
				CFG_MUL_LAT: mul_lat_q <= pwdata[5:0];
				CFG_DIV_LAT: div_lat_q <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (paddr[3:2])
			CFG_ADD_LAT: prdata = {26'd0, add_lat_q};
			CFG_MUL_LAT: prdata = {26'd0, mul_lat_q};
			CFG_DIV_LAT: prdata = {26'd0, div_lat_q};
			default:     prdata = 32'd0;
		endcase
	end

	rss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rss_dp #(
		.NUM_REGS    (NUM_REGS),
		.ADD_STATIONS(ADD_STATIONS),
		.MUL_STATIONS(MUL_STATIONS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.in_data (in_data),
		.add_lat (add_lat_q),
		.mul_lat (mul_lat_q),
		.div_lat (div_lat_q),
		.out_data(out_data)
	);
endmodule
